// File: design/nrt_pkg.sv
package nrt_pkg;

    localparam int MAX_RECORDS_DEF = 64;
    localparam int NAME_BYTES_DEF  = 32;

    // name width as carried on the request channel
    localparam int NAME_IN_W = 256;
    localparam int ROOT_W    = 32;
    localparam int FUNC_W    = 2;
    localparam int STATUS_W  = 2;

    // entry count width for the default table size
    localparam int CNT_W_DEF = $clog2(MAX_RECORDS_DEF + 1);

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

// File: design/nrt_req_if.sv
interface nrt_req_if
    import nrt_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [63:0]              name_word0;
    logic [63:0]              name_word1;
    logic [63:0]              name_word2;
    logic [63:0]              name_word3;
    logic signed [ROOT_W-1:0] root_in;

    modport source
    (
        output valid, func, name_word0, name_word1, name_word2, name_word3, root_in,
        input  ready
    );

    modport sink
    (
        input  valid, func, name_word0, name_word1, name_word2, name_word3, root_in,
        output ready
    );
endinterface

// File: design/nrt_rsp_if.sv
interface nrt_rsp_if
    import nrt_pkg::*;
#(
    parameter int CNT_W = CNT_W_DEF
);
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [ROOT_W-1:0] root_out;
    logic [CNT_W-1:0]         entry_count;

    modport source
    (
        output valid, status, root_out, entry_count,
        input  ready
    );

    modport sink
    (
        input  valid, status, root_out, entry_count,
        output ready
    );
endinterface

// File: design/nrt_ram.sv
module nrt_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
)
(
    input  logic                              clk,
    input  logic                              we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                  wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: design/named_root_table.sv
// named_root_table: a packed table of named root ids with linear search.
//
// Channels: req (sink) carries func, the name as four 64-bit words and root_in;
// rsp (source) returns status, root_out and entry_count, one response per
// request. A request is taken on a clock edge with valid and ready both high.
// req.ready is high only while the sequencer is idle; it stays high while an
// earlier response still sits in the rsp register, so the rsp side can lag.
//
// Sequence, with n = entries held and k = index of the matching entry:
//   the name RAM is scanned from entry 0, one entry per cycle, up to entry k on
//   a hit and through all n entries on a miss (skipped for an empty table); a
//   decide state follows; a delete then shifts entries k+1 to n-1 down (read
//   entry j+1, write entry j); the done state loads rsp once the rsp register
//   is free. The next request can be taken in the cycle after the response is loaded.
//
// Reset clears the entry count and the handshake state; the RAM contents are
// not cleared, since no entry at or above the count is ever used.
// A stalled rsp.ready holds the finished response in the sequencer until the
// rsp register frees; rsp carries $clog2(MAX_RECORDS+1) bits of entry_count.
module named_root_table
    import nrt_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    nrt_req_if.sink       req,
    nrt_rsp_if.source     rsp
);
    localparam int NAME_W = NAME_BYTES * 8;
    localparam int IDX_W  = MAX_RECORDS > 1 ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W  = $clog2(MAX_RECORDS + 1);
    localparam int SUM_W  = (IDX_W > CNT_W ? IDX_W : CNT_W) + 1;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RECORDS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     found_reg, found_next;
    logic [FUNC_W-1:0]        func_reg, func_next;
    logic [NAME_W-1:0]        name_reg, name_next;
    logic [ROOT_W-1:0]        root_reg, root_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [ROOT_W-1:0]        rout_reg, rout_next;

    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [ROOT_W-1:0]        out_root_reg, out_root_next;
    logic [CNT_W-1:0]         out_count_reg, out_count_next;

    // RAM ports; both RAMs share waddr and raddr
    logic                     name_we, root_we;
    logic [IDX_W-1:0]         waddr, raddr;
    logic [NAME_W-1:0]        name_wdata, name_rdata;
    logic [ROOT_W-1:0]        root_wdata, root_rdata;

    logic [NAME_IN_W-1:0]     name_in;
    logic [SUM_W-1:0]         idx_inc, raddr_wide;
    logic                     out_free;

    assign name_in  = {req.name_word3, req.name_word2, req.name_word1, req.name_word0};
    assign idx_inc  = SUM_W'(idx_reg) + SUM_W'(1);
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.root_out    = out_root_reg;
    assign rsp.entry_count = out_count_reg;

    nrt_ram #(.WIDTH(NAME_W), .DEPTH(MAX_RECORDS)) u_name_ram
    (
        .clk   (clk),
        .we    (name_we),
        .waddr (waddr),
        .wdata (name_wdata),
        .raddr (raddr),
        .rdata (name_rdata)
    );

    nrt_ram #(.WIDTH(ROOT_W), .DEPTH(MAX_RECORDS)) u_root_ram
    (
        .clk   (clk),
        .we    (root_we),
        .waddr (waddr),
        .wdata (root_wdata),
        .raddr (raddr),
        .rdata (root_rdata)
    );

    // read address: entry 0 on accept, next entry while scanning,
    // entry idx+1 ahead of a shift, idx+2 during the shift
    always_comb
    begin
        case (state_reg)
            S_SCAN, S_DECIDE: raddr_wide = idx_inc;
            S_SHIFT:          raddr_wide = idx_inc + SUM_W'(1);
            default:          raddr_wide = '0;
        endcase
        raddr = raddr_wide[IDX_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        func_next       = func_reg;
        name_next       = name_reg;
        root_next       = root_reg;
        status_next     = status_reg;
        rout_next       = rout_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_root_next   = out_root_reg;
        out_count_next  = out_count_reg;
        name_we         = 1'b0;
        root_we         = 1'b0;
        waddr           = idx_reg;
        name_wdata      = name_rdata;
        root_wdata      = root_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next   = req.func;
                    name_next   = name_in[NAME_W-1:0];
                    root_next   = req.root_in;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    rout_next   = '0;
                    state_next  = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // RAM data belongs to entry idx_reg
                if (name_rdata == name_reg)
                begin
                    found_next = 1'b1;
                    rout_next  = root_rdata;
                    state_next = S_DECIDE;
                end
                else if (idx_inc == SUM_W'(count_reg))
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    idx_next = idx_inc[IDX_W-1:0];
                end
            end

            S_DECIDE:
            begin
                status_next = ST_DONE;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        rout_next = '0;
                        if (found_reg)
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        else if (count_reg == CNT_MAX)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            name_we    = 1'b1;
                            root_we    = 1'b1;
                            waddr      = count_reg[IDX_W-1:0];
                            name_wdata = name_reg;
                            root_wdata = root_reg;
                            count_next = count_reg + CNT_W'(1);
                        end
                        state_next = S_DONE;
                    end
                    FUNC_DELETE:
                    begin
                        rout_next = '0;
                        if (found_reg)
                        begin
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end
                    end
                    FUNC_UPDATE:
                    begin
                        rout_next = '0;
                        if (found_reg)
                        begin
                            root_we    = 1'b1;
                            root_wdata = root_reg;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_NOT_FOUND;
                            rout_next   = '0;
                        end
                        state_next = S_DONE;
                    end
                endcase
            end

            S_SHIFT:
            begin
                // RAM data belongs to entry idx_reg+1
                if (idx_inc < SUM_W'(count_reg))
                begin
                    name_we  = 1'b1;
                    root_we  = 1'b1;
                    idx_next = idx_inc[IDX_W-1:0];
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_root_next   = rout_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        func_reg       <= func_next;
        name_reg       <= name_next;
        root_reg       <= root_next;
        status_reg     <= status_next;
        rout_reg       <= rout_next;
        out_status_reg <= out_status_next;
        out_root_reg   <= out_root_next;
        out_count_reg  <= out_count_next;
    end
endmodule

// File: bench/root_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels, keeps its own copy of the named root table,
// and checks every response against the request that caused it.
module root_table_checker
    import nrt_pkg::*;
#(
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF,
    parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
)
(
    input  logic clk,
    input  logic rst_n,
    nrt_req_if   req,
    nrt_rsp_if   rsp,
    output int   errors,
    output int   awaiting,
    output int   done_seen,
    output int   miss_seen,
    output int   dup_seen,
    output int   full_seen,
    output int   peak_held
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROOT_W-1:0]   root;
        logic [CNT_W-1:0]    count;
    } table_reply_t;

    logic [NAME_IN_W-1:0] names_held [MAX_RECORDS];
    logic [ROOT_W-1:0]    roots_held [MAX_RECORDS];
    int                   held;
    table_reply_t         replies_due [$];

    // bytes past NAME_BYTES never take part in storing or matching
    function automatic logic [NAME_IN_W-1:0] visible_name(input logic [NAME_IN_W-1:0] raw);
        logic [NAME_IN_W-1:0] keep;
        keep = '0;
        for (int b = 0; b < NAME_BYTES && b < NAME_IN_W / 8; b++)
        begin
            keep[b*8 +: 8] = 8'hff;
        end
        return raw & keep;
    endfunction

    // apply one request to the table copy and return the response it earns
    function automatic table_reply_t apply_request(input logic [FUNC_W-1:0] op,
                                                   input logic [NAME_IN_W-1:0] name,
                                                   input logic [ROOT_W-1:0] root);
        table_reply_t r;
        int           hit;
        hit      = -1;
        r.status = ST_DONE;
        r.root   = '0;
        for (int i = 0; i < held; i++)
        begin
            if (hit < 0 && names_held[i] == name)
                hit = i;
        end
        case (op)
            FUNC_INSERT:
            begin
                if (hit >= 0)
                    r.status = ST_DUPLICATE;
                else if (held >= MAX_RECORDS)
                    r.status = ST_FULL;
                else
                begin
                    names_held[held] = name;
                    roots_held[held] = root;
                    held++;
                end
            end
            FUNC_DELETE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = hit; i + 1 < held; i++)
                    begin
                        names_held[i] = names_held[i+1];
                        roots_held[i] = roots_held[i+1];
                    end
                    held--;
                end
            end
            FUNC_UPDATE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    roots_held[hit] = root;
            end
            default:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    r.root = roots_held[hit];
            end
        endcase
        r.count = CNT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t due;
        if (!rst_n)
        begin
            held      = 0;
            errors    = 0;
            awaiting  = 0;
            done_seen = 0;
            miss_seen = 0;
            dup_seen  = 0;
            full_seen = 0;
            peak_held = 0;
            replies_due.delete();
        end
        else
        begin
            // a response can only belong to a request taken on an earlier edge
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("response with no request outstanding: status %0d root_out %0d",
                           rsp.status, $signed(rsp.root_out));
                    errors++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    if (rsp.status !== due.status)
                    begin
                        $error("status: expected %0d, got %0d", due.status, rsp.status);
                        errors++;
                    end
                    if (rsp.root_out !== due.root)
                    begin
                        $error("root_out: expected %0d, got %0d",
                               $signed(due.root), $signed(rsp.root_out));
                        errors++;
                    end
                    if (rsp.entry_count !== due.count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               due.count, rsp.entry_count);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                due = apply_request(req.func,
                                    visible_name({req.name_word3, req.name_word2,
                                                  req.name_word1, req.name_word0}),
                                    req.root_in);
                replies_due.push_back(due);
                case (due.status)
                    ST_DONE:      done_seen++;
                    ST_NOT_FOUND: miss_seen++;
                    ST_DUPLICATE: dup_seen++;
                    default:      full_seen++;
                endcase
                if (held > peak_held)
                    peak_held = held;
            end
            awaiting = replies_due.size();
        end
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import nrt_pkg::*;

    localparam int CNT_W  = CNT_W_DEF;
    localparam int POOL_N = 72;   // a few more names than the table holds

    // drain wait after the last response: worst delete plus margin
    localparam int DRAIN_CYCLES = 2 * MAX_RECORDS_DEF + 16;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic       clk;
    logic       rst_n;
    idle_mode_t idle_mode;

    int errors;
    int awaiting;
    int done_seen;
    int miss_seen;
    int dup_seen;
    int full_seen;
    int peak_held;
    int requests_sent;

    logic [NAME_IN_W-1:0] name_pool [POOL_N];

    nrt_req_if                 req_ch ();
    nrt_rsp_if #(.CNT_W(CNT_W)) rsp_ch ();

    named_root_table dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    root_table_checker chk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .errors    (errors),
        .awaiting  (awaiting),
        .done_seen (done_seen),
        .miss_seen (miss_seen),
        .dup_seen  (dup_seen),
        .full_seen (full_seen),
        .peak_held (peak_held)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // hard stop in case the handshake hangs
    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // stall percentages per idling phase
    function automatic int sender_idle_pct(input idle_mode_t m);
        case (m)
            IDLE_SENDER: return 56;
            IDLE_BOTH:   return 14;
            default:     return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input idle_mode_t m);
        case (m)
            IDLE_RECEIVER: return 56;
            IDLE_BOTH:     return 14;
            default:       return 0;
        endcase
    endfunction

    // name of len random bytes, zero padded to the full width
    function automatic logic [NAME_IN_W-1:0] random_name(input int len);
        logic [NAME_IN_W-1:0] nm;
        nm = '0;
        for (int b = 0; b < len; b++)
        begin
            nm[b*8 +: 8] = 8'($urandom);
        end
        return nm;
    endfunction

    // receiver: ready is redrawn at every edge according to the current phase
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
        end
    end

    // One request. Valid is driven only once per edge: either the idle
    // low or the new request high, never both in the same step.
    // Returns at the edge where the request was taken.
    task automatic send_request(input logic [FUNC_W-1:0] op,
                                input logic [NAME_IN_W-1:0] nm,
                                input logic [ROOT_W-1:0] rt);
        while ($urandom_range(99) < sender_idle_pct(idle_mode))
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= op;
        req_ch.name_word0 <= nm[63:0];
        req_ch.name_word1 <= nm[127:64];
        req_ch.name_word2 <= nm[191:128];
        req_ch.name_word3 <= nm[255:192];
        req_ch.root_in    <= rt;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    initial
    begin
        logic [NAME_IN_W-1:0] zero_name;
        logic [NAME_IN_W-1:0] ones_name;
        logic [NAME_IN_W-1:0] tail_name;
        logic [NAME_IN_W-1:0] near_name;
        logic [NAME_IN_W-1:0] nm;
        logic [ROOT_W-1:0]    rt;
        logic [FUNC_W-1:0]    op;
        int                   pick;
        int                   bitpos;
        bit                   grow;

        rst_n             = 1'b0;
        idle_mode         = IDLE_NONE;
        requests_sent     = 0;
        req_ch.valid      = 1'b0;
        req_ch.func       = FUNC_INSERT;
        req_ch.name_word0 = '0;
        req_ch.name_word1 = '0;
        req_ch.name_word2 = '0;
        req_ch.name_word3 = '0;
        req_ch.root_in    = '0;

        // half full-length names (all 32 bytes random), half short zero-padded ones
        for (int i = 0; i < POOL_N; i++)
        begin
            if (i % 2 == 0)
                name_pool[i] = random_name(32);
            else
                name_pool[i] = random_name($urandom_range(31, 1));
        end

        zero_name = '0;
        ones_name = '1;
        tail_name = '0;
        tail_name[255:248] = 8'h5a;          // only the last byte nonzero
        near_name = ones_name;
        near_name[0] = 1'b0;                  // one bit away from ones_name

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // misses on an empty table
        send_request(FUNC_LOOKUP, zero_name, 32'd0);
        send_request(FUNC_DELETE, zero_name, 32'd0);
        send_request(FUNC_UPDATE, zero_name, 32'd7);
        // extreme names and root ids
        send_request(FUNC_INSERT, zero_name, 32'h8000_0000);
        send_request(FUNC_INSERT, ones_name, 32'h7fff_ffff);
        send_request(FUNC_INSERT, tail_name, 32'hffff_ffff);
        // duplicate insert leaves the root untouched
        send_request(FUNC_INSERT, ones_name, 32'd1);
        send_request(FUNC_LOOKUP, zero_name, 32'd0);
        send_request(FUNC_LOOKUP, ones_name, 32'd0);
        send_request(FUNC_LOOKUP, tail_name, 32'd0);
        send_request(FUNC_UPDATE, ones_name, 32'd0);
        send_request(FUNC_LOOKUP, ones_name, 32'd0);
        // whole-name compare: a single flipped bit must miss
        send_request(FUNC_LOOKUP, near_name, 32'd0);
        send_request(FUNC_UPDATE, near_name, 32'd3);
        send_request(FUNC_DELETE, near_name, 32'd0);
        // delete of entry 0 shifts the rest down
        send_request(FUNC_DELETE, zero_name, 32'd0);
        send_request(FUNC_LOOKUP, tail_name, 32'd0);
        send_request(FUNC_LOOKUP, zero_name, 32'd0);
        // delete of the last entry, then drain to empty
        send_request(FUNC_DELETE, tail_name, 32'd0);
        send_request(FUNC_DELETE, ones_name, 32'd0);
        send_request(FUNC_LOOKUP, ones_name, 32'd0);
        send_request(FUNC_INSERT, near_name, 32'd5);

        // ---- random part ----
        // Eight segments; grow segments push toward a full table, shrink
        // segments drain it. Each idling phase sees both kinds.
        for (int s = 0; s < 8; s++)
        begin
            idle_mode = idle_mode_t'(s % 4);
            grow      = ((s / 4 + s) % 2) == 0;
            for (int k = 0; k < 250; k++)
            begin
                pick = $urandom_range(99);
                if (grow)
                    op = (pick < 55) ? FUNC_INSERT :
                         (pick < 65) ? FUNC_DELETE :
                         (pick < 80) ? FUNC_UPDATE : FUNC_LOOKUP;
                else
                    op = (pick < 15) ? FUNC_INSERT :
                         (pick < 60) ? FUNC_DELETE :
                         (pick < 75) ? FUNC_UPDATE : FUNC_LOOKUP;

                // mostly pool names so hits are common; some near misses
                // and some fully random names
                pick = $urandom_range(99);
                nm   = name_pool[$urandom_range(POOL_N - 1)];
                if (pick >= 94)
                    nm = {$urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom};
                else if (pick >= 88)
                begin
                    bitpos     = $urandom_range(NAME_IN_W - 1);
                    nm[bitpos] = ~nm[bitpos];
                end

                pick = $urandom_range(99);
                if (pick < 3)
                    rt = 32'h8000_0000;
                else if (pick < 6)
                    rt = 32'h7fff_ffff;
                else if (pick < 8)
                    rt = 32'd0;
                else if (pick < 10)
                    rt = 32'hffff_ffff;
                else
                    rt = $urandom;

                send_request(op, nm, rt);
            end
        end
        req_ch.valid <= 1'b0;

        // wait for every response, then a quiet spell to catch strays
        while (awaiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d done, %0d not found, %0d duplicate, %0d table full",
                 requests_sent, done_seen, miss_seen, dup_seen, full_seen);
        $display("Largest table size reached: %0d entries, over four idling phases",
                 peak_held);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
